// ===== src/tlsfp_pkg.sv =====
`timescale 1ns / 1ps

package tlsfp_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int BYTE_W      = 8;
   localparam int FLEN_W      = 6;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_RESYNC = 1'b1;

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LENGTH,
      PH_SUM,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      ST_RX,
      ST_READ,
      ST_LOAD
   } state_type;

endpackage

// ===== src/tlsfp_req_if.sv =====
`timescale 1ns / 1ps

interface tlsfp_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [tlsfp_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// ===== src/tlsfp_rsp_if.sv =====
`timescale 1ns / 1ps

interface tlsfp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tlsfp_pkg::BYTE_W-1:0]    frame_type;
   logic [tlsfp_pkg::FLEN_W-1:0]    frame_length;
   logic [tlsfp_pkg::BYTE_W-1:0]    payload_byte;
   logic                            payload_valid;
   logic                            last;

   modport source (output valid, output frame_type, output frame_length,
                   output payload_byte, output payload_valid, output last,
                   input ready);
   modport sink   (input valid, input frame_type, input frame_length,
                   input payload_byte, input payload_valid, input last,
                   output ready);
endinterface

// ===== src/tlsfp_ram.sv =====
`timescale 1ns / 1ps

module tlsfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/type_length_sum_frame_parser.sv =====
`timescale 1ns / 1ps

// Channel     Dir  Fields
// req_chan    in   command, rx_byte
// rsp_chan    out  frame_type, frame_length, payload_byte, payload_valid, last
//
// Req ready drops while the output register is full and not being taken. After a good last
// payload byte the payload buffer is read out, each result passing a RAM read state and then
// an output load state that waits while the output register is full and not being taken;
// no bytes are taken during readout.
// Reset is synchronous and returns the parser to waiting for a type byte; no clearing pass.

module type_length_sum_frame_parser (
   input  logic         clock,
   input  logic         reset,
   tlsfp_req_if.sink    req_chan,
   tlsfp_rsp_if.source  rsp_chan
);

   tlsfp_pkg::state_type              state_ff, state_in;
   tlsfp_pkg::phase_type              phase_ff, phase_in;
   logic [tlsfp_pkg::BYTE_W-1:0]      type_ff, type_in;
   logic [tlsfp_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [tlsfp_pkg::BYTE_W-1:0]      rsum_ff, rsum_in;
   logic [tlsfp_pkg::BYTE_W-1:0]      csum_ff, csum_in;
   logic [tlsfp_pkg::LEN_W-1:0]       count_ff, count_in;
   logic [tlsfp_pkg::LEN_W-1:0]       idx_ff, idx_in;

   logic                              out_valid_ff, out_valid_in;
   logic [tlsfp_pkg::BYTE_W-1:0]      out_type_ff, out_type_in;
   logic [tlsfp_pkg::FLEN_W-1:0]      out_len_ff, out_len_in;
   logic [tlsfp_pkg::BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                              out_pv_ff, out_pv_in;
   logic                              out_last_ff, out_last_in;

   logic                              out_free;
   logic                              take;
   logic [tlsfp_pkg::BYTE_W-1:0]      sum_next;
   logic [tlsfp_pkg::LEN_W-1:0]       count_next;
   logic                              wr_en;
   logic [tlsfp_pkg::BYTE_W-1:0]      rd_data;

   tlsfp_ram #(
      .WIDTH (tlsfp_pkg::BYTE_W),
      .DEPTH (tlsfp_pkg::MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[tlsfp_pkg::ADDR_W-1:0]),
      .wr_data (req_chan.rx_byte),
      .rd_addr (idx_ff[tlsfp_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == tlsfp_pkg::ST_RX) && out_free;
   assign take           = req_chan.valid && req_chan.ready;
   assign sum_next       = rsum_ff + req_chan.rx_byte;
   assign count_next     = count_ff + 1'b1;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.frame_type    = out_type_ff;
   assign rsp_chan.frame_length  = out_len_ff;
   assign rsp_chan.payload_byte  = out_byte_ff;
   assign rsp_chan.payload_valid = out_pv_ff;
   assign rsp_chan.last          = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlsfp_pkg::ST_RX;
         phase_ff     <= tlsfp_pkg::PH_TYPE;
         out_valid_ff <= 1'b0;
         type_ff      <= '0;
         len_ff       <= '0;
         rsum_ff      <= '0;
         csum_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         rsum_ff      <= rsum_in;
         csum_ff      <= csum_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
      end
      out_type_ff <= out_type_in;
      out_len_ff  <= out_len_in;
      out_byte_ff <= out_byte_in;
      out_pv_ff   <= out_pv_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      rsum_in      = rsum_ff;
      csum_in      = csum_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_type_in  = out_type_ff;
      out_len_in   = out_len_ff;
      out_byte_in  = out_byte_ff;
      out_pv_in    = out_pv_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         tlsfp_pkg::ST_RX: begin
            if (take) begin
               if (req_chan.command == tlsfp_pkg::CMD_RESYNC) begin
                  phase_in = tlsfp_pkg::PH_TYPE;
               end else begin
                  case (phase_ff)
                     tlsfp_pkg::PH_TYPE: begin
                        type_in  = req_chan.rx_byte;
                        rsum_in  = req_chan.rx_byte;
                        phase_in = tlsfp_pkg::PH_LENGTH;
                     end
                     tlsfp_pkg::PH_LENGTH: begin
                        len_in  = req_chan.rx_byte[tlsfp_pkg::LEN_W-1:0];
                        rsum_in = sum_next;
                        if (req_chan.rx_byte > 8'(tlsfp_pkg::MAX_PAYLOAD)) begin
                           phase_in = tlsfp_pkg::PH_TYPE;
                        end else begin
                           phase_in = tlsfp_pkg::PH_SUM;
                        end
                     end
                     tlsfp_pkg::PH_SUM: begin
                        csum_in  = req_chan.rx_byte;
                        count_in = '0;
                        if (len_ff == '0) begin
                           phase_in = tlsfp_pkg::PH_TYPE;
                           if (rsum_ff == req_chan.rx_byte) begin
                              out_valid_in = 1'b1;
                              out_type_in  = type_ff;
                              out_len_in   = tlsfp_pkg::FLEN_W'(len_ff);
                              out_byte_in  = '0;
                              out_pv_in    = 1'b0;
                              out_last_in  = 1'b1;
                           end
                        end else begin
                           phase_in = tlsfp_pkg::PH_DATA;
                        end
                     end
                     default: begin
                        wr_en    = 1'b1;
                        count_in = count_next;
                        rsum_in  = sum_next;
                        if (count_next == len_ff) begin
                           phase_in = tlsfp_pkg::PH_TYPE;
                           if (sum_next == csum_ff) begin
                              idx_in   = '0;
                              state_in = tlsfp_pkg::ST_READ;
                           end
                        end
                     end
                  endcase
               end
            end
         end
         tlsfp_pkg::ST_READ: begin
            state_in = tlsfp_pkg::ST_LOAD;
         end
         tlsfp_pkg::ST_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_type_in  = type_ff;
               out_len_in   = tlsfp_pkg::FLEN_W'(len_ff);
               out_byte_in  = rd_data;
               out_pv_in    = 1'b1;
               out_last_in  = (idx_ff + 1'b1) == len_ff;
               idx_in       = idx_ff + 1'b1;
               if ((idx_ff + 1'b1) == len_ff) begin
                  state_in = tlsfp_pkg::ST_RX;
               end else begin
                  state_in = tlsfp_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = tlsfp_pkg::ST_RX;
         end
      endcase
   end

endmodule
